### src/hsct_pkg.sv
// Package for the hall six-step commutation throttle block.
// Holds channel payload types, register codes, reset values and commutation tables.
// No dependencies.
`default_nettype none

package hsct_pkg;

	// Field widths.
	localparam int HALL_W   = 3;
	localparam int LEVEL_W  = 12;
	localparam int PERIOD_W = 16;
	localparam int GATE_W   = 6;
	localparam int DUTY_W   = 16;
	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Serial divider sizing: (throttle - stop_level) * pwm_period over a level span.
	localparam int DIVIDEND_W = LEVEL_W + PERIOD_W;
	localparam int DIVISOR_W  = LEVEL_W;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_START_LEVEL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_STOP_LEVEL  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FULL_LEVEL  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD  = 2'd3;

	// Register reset values.
	localparam logic [LEVEL_W-1:0]  START_LEVEL_RST = 12'd200;
	localparam logic [LEVEL_W-1:0]  STOP_LEVEL_RST  = 12'd50;
	localparam logic [LEVEL_W-1:0]  FULL_LEVEL_RST  = 12'd4000;
	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST  = 16'd4500;

	// Gate patterns indexed by hall code; codes 0 and 7 turn every gate off.
	localparam logic [GATE_W-1:0] FWD_PATTERN [8] = '{
		6'h00, 6'h12, 6'h09, 6'h18, 6'h24, 6'h06, 6'h21, 6'h00
	};
	localparam logic [GATE_W-1:0] BWD_PATTERN [8] = '{
		6'h00, 6'h21, 6'h06, 6'h24, 6'h18, 6'h09, 6'h12, 6'h00
	};

	typedef struct packed {
		logic [HALL_W-1:0]  hall_code;
		logic [LEVEL_W-1:0] throttle;
		logic               direction_switch;
	} in_item_t;

	typedef struct packed {
		logic [GATE_W-1:0] gate_enables;
		logic [DUTY_W-1:0] duty_count;
		logic              motor_running;
		logic              spin_direction;
	} out_item_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] wr_data;
	} cfg_wr_t;

	// Divider handshake.
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

### src/hsct_chan_if.sv
// Valid/ready channel carrying one payload beat of a chosen type.
// Depends on nothing; payload types come from hsct_pkg at instantiation.
`default_nettype none

interface hsct_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/hall_six_step_commutation_throttle.sv
// Top level: six-step hall commutation with throttle hysteresis and duty ramp.
// Depends on hsct_pkg, hsct_chan_if and hsct_div.
//
// Channel   Role  Payload                                              Notes
// samples   sink  hall_code, throttle, direction_switch                one sample per beat
// results   src   gate_enables, duty_count, motor_running, spin_dir.  one result per sample
// cfg       sink  reg_index, wr_data                                  always ready
//
// A sample on the duty ramp goes through the 12x16 multiply, then the serial divider over
// the 28-bit dividend, one quotient bit per cycle, plus sequencing.
// Samples that need no division (stop, hysteresis band, clamp) skip to the output state.
// samples.ready is high only while the sequencer is idle.
// A result waits in the output register while results.ready is low; the next sample
// may be accepted meanwhile but its result holds in the sequencer until the register frees.
// Reset returns the registers to their defaults and the motor to stopped.
`default_nettype none

module hall_six_step_commutation_throttle (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hsct_chan_if.sink   samples,
	hsct_chan_if.source results,
	hsct_chan_if.sink   cfg
);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE      = 3'd0;
	localparam logic [ST_W-1:0] ST_MUL       = 3'd1;
	localparam logic [ST_W-1:0] ST_DIV_START = 3'd2;
	localparam logic [ST_W-1:0] ST_DIV_WAIT  = 3'd3;
	localparam logic [ST_W-1:0] ST_OUT       = 3'd4;

	logic [ST_W-1:0] st_q;

	// Configuration registers.
	logic [hsct_pkg::LEVEL_W-1:0]  start_level_q;
	logic [hsct_pkg::LEVEL_W-1:0]  stop_level_q;
	logic [hsct_pkg::LEVEL_W-1:0]  full_level_q;
	logic [hsct_pkg::PERIOD_W-1:0] pwm_period_q;

	// Motor state.
	logic                        running_q;
	logic                        direction_q;
	logic [hsct_pkg::DUTY_W-1:0] duty_q;

	// Sample payload held during the computation.
	logic [hsct_pkg::HALL_W-1:0]     hall_q;
	logic [hsct_pkg::LEVEL_W-1:0]    thr_q;
	logic [hsct_pkg::DIVIDEND_W-1:0] product_q;

	// Output register.
	logic                  res_valid_q;
	hsct_pkg::out_item_t   res_q;

	logic                        accept;
	logic                        above_start;
	logic                        below_stop;
	logic                        clamp_full;
	logic [hsct_pkg::DUTY_W-1:0] ceiling;
	logic [hsct_pkg::LEVEL_W-1:0] ramp_offset;
	logic                        out_free;
	logic [hsct_pkg::GATE_W-1:0] gates;

	hsct_pkg::div_ctl_t                div_ctl;
	hsct_pkg::div_sts_t                div_sts;
	logic [hsct_pkg::DIVIDEND_W-1:0]   quotient;
	logic [hsct_pkg::DIVISOR_W-1:0]    span;

	// Handshakes.
	assign samples.ready = (st_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !res_valid_q || results.ready;

	// Threshold compares on the incoming sample.
	assign above_start = samples.data.throttle > start_level_q;
	assign below_stop  = samples.data.throttle < stop_level_q;
	assign clamp_full  = (samples.data.throttle > full_level_q) || (full_level_q <= start_level_q);

	// Duty ceiling is period + 1, saturated to the duty width.
	assign ceiling = (pwm_period_q == '1) ? '1 : pwm_period_q + 1'b1;

	assign ramp_offset = thr_q - stop_level_q;
	assign span        = full_level_q - start_level_q;
	assign div_ctl.start = (st_q == ST_DIV_START);

	hsct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (product_q),
		.divisor  (span),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= hsct_pkg::START_LEVEL_RST;
			stop_level_q  <= hsct_pkg::STOP_LEVEL_RST;
			full_level_q  <= hsct_pkg::FULL_LEVEL_RST;
			pwm_period_q  <= hsct_pkg::PWM_PERIOD_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.reg_index)
				hsct_pkg::REG_START_LEVEL:
					start_level_q <= cfg.data.wr_data[hsct_pkg::LEVEL_W-1:0];
				hsct_pkg::REG_STOP_LEVEL:
					stop_level_q <= cfg.data.wr_data[hsct_pkg::LEVEL_W-1:0];
				hsct_pkg::REG_FULL_LEVEL:
					full_level_q <= cfg.data.wr_data[hsct_pkg::LEVEL_W-1:0];
				hsct_pkg::REG_PWM_PERIOD:
					pwm_period_q <= cfg.data.wr_data[hsct_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and motor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			running_q   <= 1'b0;
			direction_q <= 1'b0;
			duty_q      <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_OUT;
						if (above_start) begin
							if (!running_q) begin
								running_q   <= 1'b1;
								direction_q <= samples.data.direction_switch;
							end
							if (below_stop) begin
								duty_q <= '0;
							end else if (clamp_full) begin
								duty_q <= ceiling;
							end else begin
								st_q <= ST_MUL;
							end
						end else if (running_q && below_stop) begin
							running_q <= 1'b0;
							duty_q    <= '0;
						end
					end
				end
				ST_MUL: begin
					st_q <= ST_DIV_START;
				end
				ST_DIV_START: begin
					st_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_sts.done) begin
						st_q <= ST_OUT;
						if (quotient > hsct_pkg::DIVIDEND_W'(ceiling)) begin
							duty_q <= ceiling;
						end else begin
							duty_q <= quotient[hsct_pkg::DUTY_W-1:0];
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample payload and the ramp product.
	always_ff @(posedge clk) begin
		if (accept) begin
			hall_q <= samples.data.hall_code;
			thr_q  <= samples.data.throttle;
		end
		if (st_q == ST_MUL) begin
			product_q <= hsct_pkg::DIVIDEND_W'(ramp_offset) *
				hsct_pkg::DIVIDEND_W'(pwm_period_q);
		end
	end

	// Gate pattern from the commutation tables; all off while stopped.
	always_comb begin
		if (!running_q) begin
			gates = '0;
		end else if (direction_q) begin
			gates = hsct_pkg::FWD_PATTERN[hall_q];
		end else begin
			gates = hsct_pkg::BWD_PATTERN[hall_q];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((st_q == ST_OUT) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if ((st_q == ST_OUT) && out_free) begin
			res_q.gate_enables  <= gates;
			res_q.duty_count    <= duty_q;
			res_q.motor_running <= running_q;
			res_q.spin_direction <= direction_q;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	// The divider only runs while the sequencer waits on it.
	a_div_busy_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (st_q == ST_DIV_WAIT))
		else $error("divider busy outside the divide wait");

	// A finished division is only reported while the sequencer waits for it.
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (st_q == ST_DIV_WAIT))
		else $error("divider done outside the divide wait");

	// An accepted sample always takes the sequencer out of idle.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q != ST_IDLE))
		else $error("sequencer stayed idle after a sample beat");

	// A stopped motor never drives any gate.
	a_stopped_gates_off: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.data.motor_running) |-> (results.data.gate_enables == '0))
		else $error("gates enabled while the motor is stopped");

endmodule

`default_nettype wire

### src/hsct_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on hsct_pkg for operand widths and the control/status structs.
`default_nettype none

module hsct_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire hsct_pkg::div_ctl_t             ctl,
	input  wire logic [hsct_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [hsct_pkg::DIVISOR_W-1:0]  divisor,
	output hsct_pkg::div_sts_t                  sts,
	output logic [hsct_pkg::DIVIDEND_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(hsct_pkg::DIVIDEND_W + 1);

	logic [CNT_W-1:0]                   cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [hsct_pkg::DIVISOR_W-1:0]     rem_q;
	logic [hsct_pkg::DIVIDEND_W-1:0]    quo_q;
	logic [hsct_pkg::DIVISOR_W:0]       trial;
	logic                               fits;

	// Bring down the next dividend bit and try one subtraction.
	assign trial = {rem_q, quo_q[hsct_pkg::DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q  <= CNT_W'(hsct_pkg::DIVIDEND_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= hsct_pkg::DIVISOR_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[hsct_pkg::DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[hsct_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for the hall six-step commutation throttle block.
// Needs hsct_pkg, hsct_chan_if and the block's RTL. It predicts every result beat
// and drives the sample and register channels across several register settings.
`timescale 1ns / 100ps

module testbench;

	localparam longint unsigned DUTY_TOP = (64'd1 << hsct_pkg::DUTY_W) - 1;
	localparam int LEVEL_TOP = (1 << hsct_pkg::LEVEL_W) - 1;

	// Commutation tables indexed by hall code; codes 0 and 7 give all gates off.
	localparam logic [hsct_pkg::GATE_W-1:0] CW_GATES [8] = '{
		6'h00, 6'h12, 6'h09, 6'h18, 6'h24, 6'h06, 6'h21, 6'h00
	};
	localparam logic [hsct_pkg::GATE_W-1:0] CCW_GATES [8] = '{
		6'h00, 6'h21, 6'h06, 6'h24, 6'h18, 6'h09, 6'h12, 6'h00
	};

	logic clk;
	logic arst_n;

	hsct_chan_if #(.T(hsct_pkg::in_item_t))  samples_if ();
	hsct_chan_if #(.T(hsct_pkg::out_item_t)) results_if ();
	hsct_chan_if #(.T(hsct_pkg::cfg_wr_t))   cfg_if ();

	hall_six_step_commutation_throttle dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// Predicted copy of the registers and of the motor state.
	logic [hsct_pkg::LEVEL_W-1:0]  lvl_start;
	logic [hsct_pkg::LEVEL_W-1:0]  lvl_stop;
	logic [hsct_pkg::LEVEL_W-1:0]  lvl_full;
	logic [hsct_pkg::PERIOD_W-1:0] period;
	logic                          running;
	logic                          dir_latched;
	logic [hsct_pkg::DUTY_W-1:0]   duty_held;

	hsct_pkg::in_item_t  pending_samples[$];
	hsct_pkg::out_item_t expected_results[$];

	int sent_count;
	int got_count;
	int err_count;
	int queued_count;
	int hold_left;
	int next_hold_at;

	// Throttle to duty ramp, saturated at the period plus one.
	function automatic logic [hsct_pkg::DUTY_W-1:0] ramp_duty(
		logic [hsct_pkg::LEVEL_W-1:0] thr);
		longint unsigned ceiling;
		longint unsigned diff;
		longint unsigned span;
		longint unsigned quot;
		ceiling = 64'(period) + 64'd1;
		if (ceiling > DUTY_TOP)
			ceiling = DUTY_TOP;
		if (thr < lvl_stop)
			return '0;
		if (thr > lvl_full || lvl_full <= lvl_start)
			return ceiling[hsct_pkg::DUTY_W-1:0];
		diff = 64'(thr);
		diff = diff - 64'(lvl_stop);
		span = 64'(lvl_full);
		span = span - 64'(lvl_start);
		quot = (diff * 64'(period)) / span;
		if (quot > ceiling)
			quot = ceiling;
		return quot[hsct_pkg::DUTY_W-1:0];
	endfunction

	// Advances the predicted motor state by one sample and returns the result beat.
	function automatic hsct_pkg::out_item_t commutate(hsct_pkg::in_item_t s);
		hsct_pkg::out_item_t r;
		if (s.throttle > lvl_start) begin
			if (!running) begin
				running     = 1'b1;
				dir_latched = s.direction_switch;
			end
			duty_held = ramp_duty(s.throttle);
		end else if (running && s.throttle < lvl_stop) begin
			running   = 1'b0;
			duty_held = '0;
		end
		if (!running)
			r.gate_enables = '0;
		else if (dir_latched)
			r.gate_enables = CW_GATES[s.hall_code];
		else
			r.gate_enables = CCW_GATES[s.hall_code];
		r.duty_count     = duty_held;
		r.motor_running  = running;
		r.spin_direction = dir_latched;
		return r;
	endfunction

	function automatic void push_sample(logic [hsct_pkg::HALL_W-1:0] hall,
		logic [hsct_pkg::LEVEL_W-1:0] thr, logic dir);
		hsct_pkg::in_item_t s;
		s.hall_code        = hall;
		s.throttle         = thr;
		s.direction_switch = dir;
		pending_samples.push_back(s);
		queued_count++;
	endfunction

	function automatic logic [hsct_pkg::LEVEL_W-1:0] clamp_level(int v);
		if (v < 0)
			return '0;
		if (v > LEVEL_TOP)
			return hsct_pkg::LEVEL_W'(LEVEL_TOP);
		return v[hsct_pkg::LEVEL_W-1:0];
	endfunction

	function automatic logic [hsct_pkg::LEVEL_W-1:0] near_level(int center);
		return clamp_level(center + int'($urandom_range(8)) - 4);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [hsct_pkg::LEVEL_W-1:0] rand_level(int lo, int hi);
		return hsct_pkg::LEVEL_W'($urandom_range(lo, hi));
	endfunction

	// Mostly valid hall codes, now and then one of the two invalid ones.
	function automatic logic [hsct_pkg::HALL_W-1:0] pick_hall();
		if ($urandom_range(99) < 12)
			return rand_bit() ? 3'd7 : 3'd0;
		return hsct_pkg::HALL_W'($urandom_range(1, 6));
	endfunction

	// Throttle while running: around each threshold, at either end of the range, or anywhere.
	function automatic logic [hsct_pkg::LEVEL_W-1:0] pick_running_throttle();
		case ($urandom_range(5))
			0: return near_level(int'(lvl_start));
			1: return near_level(int'(lvl_stop));
			2: return near_level(int'(lvl_full));
			3: return rand_bit() ? 12'd0 : 12'(LEVEL_TOP);
			default: return rand_level(0, LEVEL_TOP);
		endcase
	endfunction

	// A throttle above the start level (or at the top), a run of samples, then one below stop (or 0).
	function automatic void queue_drive_cycle();
		int len;
		len = int'($urandom_range(3, 8));
		if (int'(lvl_start) == LEVEL_TOP)
			push_sample(pick_hall(), lvl_start, rand_bit());
		else
			push_sample(pick_hall(), rand_level(int'(lvl_start) + 1, LEVEL_TOP),
				rand_bit());
		repeat (len)
			push_sample(pick_hall(), pick_running_throttle(), rand_bit());
		if (lvl_stop == '0)
			push_sample(pick_hall(), '0, rand_bit());
		else
			push_sample(pick_hall(), rand_level(0, int'(lvl_stop) - 1), rand_bit());
	endfunction

	// Waits until every sample is taken and every result has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() != 0 || expected_results.size() != 0
			|| samples_if.valid)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [hsct_pkg::REG_IDX_W-1:0] idx,
		logic [hsct_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{reg_index: idx, wr_data: val};
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			hsct_pkg::REG_START_LEVEL: lvl_start = val[hsct_pkg::LEVEL_W-1:0];
			hsct_pkg::REG_STOP_LEVEL:  lvl_stop  = val[hsct_pkg::LEVEL_W-1:0];
			hsct_pkg::REG_FULL_LEVEL:  lvl_full  = val[hsct_pkg::LEVEL_W-1:0];
			hsct_pkg::REG_PWM_PERIOD:  period    = val[hsct_pkg::PERIOD_W-1:0];
			default: ;
		endcase
	endtask

	// Level writes carry random upper bits, which the block must drop.
	task automatic set_levels(int start_v, int stop_v, int full_v, int period_v);
		write_reg(hsct_pkg::REG_START_LEVEL, {4'($urandom), 12'(start_v)});
		write_reg(hsct_pkg::REG_STOP_LEVEL, {4'($urandom), 12'(stop_v)});
		write_reg(hsct_pkg::REG_FULL_LEVEL, {4'($urandom), 12'(full_v)});
		write_reg(hsct_pkg::REG_PWM_PERIOD, 16'(period_v));
	endtask

	// Mostly drive cycles, the rest single samples of random content.
	task automatic run_phase(int n);
		int goal;
		goal = queued_count + n;
		while (queued_count < goal) begin
			if ($urandom_range(99) < 75)
				queue_drive_cycle();
			else
				push_sample(hsct_pkg::HALL_W'($urandom_range(7)), rand_level(0, LEVEL_TOP),
					rand_bit());
		end
		wait_drained();
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample driver: offers the next pending sample, idling at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
			samples_if.data  <= '0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				expected_results.push_back(commutate(samples_if.data));
				sent_count++;
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (pending_samples.size() != 0 && ((sent_count >= 300 && sent_count < 420)
					|| $urandom_range(99) >= 38)) begin
					samples_if.data  <= pending_samples.pop_front();
					samples_if.valid <= 1'b1;
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each beat and drives ready, with long hold-offs after 150 beats and every 400 after.
	always @(posedge clk) begin
		hsct_pkg::out_item_t want;
		hsct_pkg::out_item_t seen;
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				seen = results_if.data;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: %p", seen);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (seen.gate_enables !== want.gate_enables) begin
						$error("gate_enables: expected %0h, actual %0h",
							want.gate_enables, seen.gate_enables);
						err_count++;
					end
					if (seen.duty_count !== want.duty_count) begin
						$error("duty_count: expected %0d, actual %0d",
							want.duty_count, seen.duty_count);
						err_count++;
					end
					if (seen.motor_running !== want.motor_running) begin
						$error("motor_running: expected %0b, actual %0b",
							want.motor_running, seen.motor_running);
						err_count++;
					end
					if (seen.spin_direction !== want.spin_direction) begin
						$error("spin_direction: expected %0b, actual %0b",
							want.spin_direction, seen.spin_direction);
						err_count++;
					end
				end
				got_count++;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else if (got_count >= next_hold_at) begin
				hold_left = 400;
				next_hold_at += 400;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= (got_count >= 300 && got_count < 420)
					|| $urandom_range(99) >= 38;
			end
		end
	end

	// Stimulus sequence and end of run.
	initial begin
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.data   = '0;
		results_if.ready  = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.data       = '0;
		lvl_start         = 12'd200;
		lvl_stop          = 12'd50;
		lvl_full          = 12'd4000;
		period            = 16'd4500;
		running           = 1'b0;
		dir_latched       = 1'b0;
		duty_held         = '0;
		sent_count        = 0;
		got_count         = 0;
		err_count         = 0;
		queued_count      = 0;
		hold_left         = 0;
		next_hold_at      = 150;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed samples at the reset register values.
		push_sample(3'd3, 12'd0, 1'b1);     // stopped: all gates off
		push_sample(3'd1, 12'd200, 1'b1);   // at the start level, no start
		push_sample(3'd6, 12'd100, 1'b0);
		push_sample(3'd7, 12'd0, 1'b1);
		push_sample(3'd5, 12'd201, 1'b1);   // starts clockwise
		push_sample(3'd0, 12'd1000, 1'b0);  // invalid hall code
		push_sample(3'd7, 12'd1000, 1'b1);  // invalid hall code
		push_sample(3'd1, 12'd4000, 1'b1);  // ramp overshoot
		push_sample(3'd2, 12'd4001, 1'b0);  // above full level
		push_sample(3'd3, 12'd4095, 1'b1);
		push_sample(3'd4, 12'd150, 1'b1);   // hysteresis band holds duty
		push_sample(3'd5, 12'd200, 1'b1);
		push_sample(3'd6, 12'd50, 1'b1);
		push_sample(3'd1, 12'd49, 1'b1);    // stops
		push_sample(3'd2, 12'd4095, 1'b0);  // starts counter-clockwise
		push_sample(3'd3, 12'd2000, 1'b1);  // direction stays latched
		push_sample(3'd4, 12'd3000, 1'b1);
		push_sample(3'd5, 12'd1500, 1'b0);
		push_sample(3'd6, 12'd100, 1'b1);
		push_sample(3'd1, 12'd0, 1'b1);     // stops
		wait_drained();
		run_phase(100);

		// Zero levels, a one-step span and a period one below the largest: ceiling reaches the top duty value.
		set_levels(0, 0, 1, 65534);
		run_phase(100);
		// Top levels and a period of one.
		set_levels(4095, 4095, 4095, 1);
		run_phase(60);
		// Empty ramp span.
		set_levels(1000, 500, 0, 30000);
		run_phase(100);
		// Stop level above start level: low throttle on the ramp gives zero.
		set_levels(300, 1000, 4095, 20000);
		run_phase(100);

		repeat (4) begin
			int s_v;
			int p_v;
			s_v = ($urandom_range(99) < 20) ? int'($urandom_range(64))
				: int'($urandom_range(LEVEL_TOP));
			p_v = ($urandom_range(99) < 30) ? int'($urandom_range(1, 100))
				: int'($urandom_range(1, 65534));
			set_levels(s_v,
				($urandom_range(99) < 70) ? int'($urandom_range(s_v))
					: int'($urandom_range(LEVEL_TOP)),
				($urandom_range(99) < 75) ? int'($urandom_range(s_v, LEVEL_TOP))
					: int'($urandom_range(LEVEL_TOP)),
				p_v);
			run_phase(85);
		end

		// Let any stray beat show up before the verdict.
		repeat (64) @(posedge clk);
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
